// ===== rtl/core/ogcl_pkg.sv =====
`timescale 1ns / 1ps

package ogcl_pkg;

	localparam int unsigned IN_BITS   = 81;
	localparam int unsigned IN_BYTES  = (IN_BITS + 7) / 8;
	localparam int unsigned OUT_BITS  = 20;
	localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

	localparam logic [15:0] LEAF_FLAG = 16'h8000;
	localparam logic [15:0] LEAF_MASK = 16'h7fff;

	// Configuration register indexes.
	localparam logic [2:0] REG_GRID_X     = 3'd0;
	localparam logic [2:0] REG_GRID_Y     = 3'd1;
	localparam logic [2:0] REG_GRID_Z     = 3'd2;
	localparam logic [2:0] REG_TREE_DEPTH = 3'd3;
	localparam logic [2:0] REG_NODE_COUNT = 3'd4;
	localparam logic [2:0] REG_LIST_COUNT = 3'd5;

	typedef enum logic [1:0] {
		CMD_WR_COARSE = 2'd0,
		CMD_WR_NODE   = 2'd1,
		CMD_LOOKUP    = 2'd2,
		CMD_RESERVED  = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		RES_WRITTEN  = 3'd0,
		RES_EMPTY    = 3'd1,
		RES_LEAF     = 3'd2,
		RES_BAD_NODE = 3'd3,
		RES_BAD_LEAF = 3'd4,
		RES_OUTSIDE  = 3'd5,
		RES_BAD_ADDR = 3'd6
	} result_e;

	typedef enum logic [2:0] {
		DK_EMPTY,
		DK_LEAF,
		DK_BAD_LEAF,
		DK_BAD_NODE,
		DK_DESCEND
	} desc_kind_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL2,
		S_CHECK,
		S_WALK
	} state_e;

	typedef struct packed {
		logic [15:0] cell_z;
		logic [15:0] cell_y;
		logic [15:0] cell_x;
		logic [15:0] word_value;
		logic [2:0]  child_slot;
		logic [11:0] table_address;
		cmd_e        command;
	} item_t;

	typedef struct packed {
		logic [1:0]  levels_used;
		logic [14:0] leaf_index;
		result_e     status;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_item;
		logic    write_en;
		logic    load_t;
		logic    load_idx;
		logic    start_walk;
		logic    step_walk;
		logic    load_result;
		result_e result;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_e       cmd;
		logic       wr_addr_bad;
		logic       dim_zero;
		logic       outside;
		logic       t_ovf;
		logic       idx_ovf;
		desc_kind_e kind;
		logic       out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/octree_grid_cell_lookup_top.sv =====
`timescale 1ns / 1ps

// Sparse octree cell lookup. Each input beat is one command: write a coarse
// descriptor, write one child word of an internal node, or look up a fine grid
// cell. Every command returns exactly one result beat carrying a status code,
// the cell-list index on a leaf hit, and the number of tree levels descended.
// A lookup finds its coarse cell from the coordinates shifted by the tree
// depth, reads that cell's descriptor and then follows node children, one node
// table read per level, until it meets an empty word, a leaf or an error.
// Commands are worked one at a time. A write, the unused command, and a lookup
// stopped by an empty coarse axis or a cell outside the grid finish in
// S_DECODE. A lookup whose first partial index overflows finishes in S_MUL2,
// and one whose coarse index falls past the table in S_CHECK. Every other
// lookup passes S_DECODE and S_MUL2, which form the dependent multiply steps
// for the coarse index, and the S_CHECK range check, then makes one registered
// memory read per descriptor visited in S_WALK, descending 0 to 3 levels.
// A finished command waits in its last state while the previous result is
// still unclaimed. The result register sits between the core and the output
// side, so the next command is taken while a finished result still waits.
// Table contents are not cleared by reset and must be written before they are
// read. The user must see that configuration is written only while no
// command is in flight; the block itself does not enforce it.
module octree_grid_cell_lookup_top
	import ogcl_pkg::*;
#(
	parameter int unsigned COARSE_WORDS = 4096,
	parameter int unsigned NODE_ENTRIES = 1024,
	parameter int unsigned MAX_DEPTH    = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// From bit 0: command[1:0], table_address[13:2], child_slot[16:14],
	// word_value[32:17], cell_x[48:33], cell_y[64:49], cell_z[80:65], zero pad.
	input  logic [IN_BYTES*8-1:0]  s_axis_tdata,
	// Output stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// From bit 0: status[2:0], leaf_index[17:3], levels_used[19:18], zero pad.
	output logic [OUT_BYTES*8-1:0] m_axis_tdata,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [15:0]            cfg_wdata
);

	item_t   item;
	result_t result;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The item struct is declared last field first, so its packed image
	// matches the bus layout bit for bit.
	assign item = item_t'(s_axis_tdata[IN_BITS-1:0]);

	ogcl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	ogcl_dp #(
		.COARSE_WORDS (COARSE_WORDS),
		.NODE_ENTRIES (NODE_ENTRIES),
		.MAX_DEPTH    (MAX_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, result};

endmodule

// ===== rtl/core/ogcl_ram.sv =====
`timescale 1ns / 1ps

module ogcl_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/ogcl_ctrl.sv =====
`timescale 1ns / 1ps

module ogcl_ctrl
	import ogcl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_axis_tvalid,
	output logic    s_axis_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. A finishing state waits in place while a full result is unclaimed.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.cmd == CMD_LOOKUP && !sts.dim_zero && !sts.outside) begin
					state_d = S_MUL2;
				end else if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_MUL2: begin
				if (!sts.t_ovf) begin
					state_d = S_CHECK;
				end else if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_CHECK: begin
				if (!sts.idx_ovf) begin
					state_d = S_WALK;
				end else if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (sts.kind != DK_DESCEND && sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		cmd.result    = RES_BAD_ADDR;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load_item = s_axis_tvalid;
			end
			S_DECODE: begin
				unique case (sts.cmd)
					CMD_WR_COARSE, CMD_WR_NODE: begin
						cmd.result      = sts.wr_addr_bad ? RES_BAD_ADDR : RES_WRITTEN;
						cmd.load_result = sts.out_free;
						cmd.write_en    = sts.out_free && !sts.wr_addr_bad;
					end
					CMD_LOOKUP: begin
						if (!sts.dim_zero && !sts.outside) begin
							cmd.load_t = 1'b1;
						end else begin
							cmd.result      = sts.dim_zero ? RES_BAD_ADDR : RES_OUTSIDE;
							cmd.load_result = sts.out_free;
						end
					end
					CMD_RESERVED: begin
						cmd.result      = RES_BAD_ADDR;
						cmd.load_result = sts.out_free;
					end
					default: cmd.result = RES_BAD_ADDR;
				endcase
			end
			S_MUL2: begin
				if (!sts.t_ovf) begin
					cmd.load_idx = 1'b1;
				end else begin
					cmd.load_result = sts.out_free;
				end
			end
			S_CHECK: begin
				if (!sts.idx_ovf) begin
					cmd.start_walk = 1'b1;
				end else begin
					cmd.load_result = sts.out_free;
				end
			end
			S_WALK: begin
				unique case (sts.kind)
					DK_DESCEND: cmd.step_walk = 1'b1;
					DK_EMPTY: begin
						cmd.result      = RES_EMPTY;
						cmd.load_result = sts.out_free;
					end
					DK_LEAF: begin
						cmd.result      = RES_LEAF;
						cmd.load_result = sts.out_free;
					end
					DK_BAD_LEAF: begin
						cmd.result      = RES_BAD_LEAF;
						cmd.load_result = sts.out_free;
					end
					DK_BAD_NODE: begin
						cmd.result      = RES_BAD_NODE;
						cmd.load_result = sts.out_free;
					end
					default: cmd.result = RES_BAD_NODE;
				endcase
			end
			default: s_axis_tready = 1'b0;
		endcase
	end

endmodule

// ===== rtl/core/ogcl_dp.sv =====
`timescale 1ns / 1ps

module ogcl_dp
	import ogcl_pkg::*;
#(
	parameter int unsigned COARSE_WORDS = 4096,
	parameter int unsigned NODE_ENTRIES = 1024,
	parameter int unsigned MAX_DEPTH    = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_result
);

	localparam int unsigned CAW = (COARSE_WORDS > 1) ? $clog2(COARSE_WORDS) : 1;
	localparam int unsigned NAW = $clog2(NODE_ENTRIES * 8);

	// Configuration registers.
	logic [15:0] grid_x_q, grid_y_q, grid_z_q, list_count_q;
	logic [1:0]  tree_depth_q;
	logic [10:0] node_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q     <= 16'd1;
			grid_y_q     <= 16'd1;
			grid_z_q     <= 16'd1;
			tree_depth_q <= 2'd0;
			node_count_q <= 11'd1;
			list_count_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_X:     grid_x_q     <= cfg_wdata;
				REG_GRID_Y:     grid_y_q     <= cfg_wdata;
				REG_GRID_Z:     grid_z_q     <= cfg_wdata;
				REG_TREE_DEPTH: tree_depth_q <= cfg_wdata[1:0];
				REG_NODE_COUNT: node_count_q <= cfg_wdata[10:0];
				REG_LIST_COUNT: list_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Item held for the duration of the command.
	item_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	logic [1:0]  depth;
	logic [15:0] cx, cy, cz, xs, ys, zs;

	assign depth = (tree_depth_q > 2'(MAX_DEPTH)) ? 2'(MAX_DEPTH) : tree_depth_q;
	assign cx    = grid_x_q >> depth;
	assign cy    = grid_y_q >> depth;
	assign cz    = grid_z_q >> depth;
	assign xs    = item_q.cell_x >> depth;
	assign ys    = item_q.cell_y >> depth;
	assign zs    = item_q.cell_z >> depth;

	// Coarse index in two multiply steps. If the first partial index already
	// reaches 2^16 the final index cannot fit any coarse table, so only its low
	// 16 bits enter the second multiply.
	logic [32:0] t_q, idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load_t) begin
			t_q <= 33'(32'(xs) * 32'(cy)) + 33'(ys);
		end
		if (cmd.load_idx) begin
			idx_q <= 33'(32'(t_q[15:0]) * 32'(cz)) + 33'(zs);
		end
	end

	// Tree walk state.
	logic [1:0] level_q, levels_q;
	logic       from_node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 2'd0;
			levels_q    <= 2'd0;
			from_node_q <= 1'b0;
		end else if (cmd.load_item) begin
			levels_q <= 2'd0;
		end else if (cmd.start_walk) begin
			level_q     <= depth;
			levels_q    <= 2'd0;
			from_node_q <= 1'b0;
		end else if (cmd.step_walk) begin
			level_q     <= level_q - 2'd1;
			levels_q    <= levels_q + 2'd1;
			from_node_q <= 1'b1;
		end
	end

	logic [15:0] coarse_rdata, node_rdata, desc;
	logic [1:0]  lvl_m1;
	logic [3:0]  xb, yb, zb;
	logic [2:0]  child;
	logic [14:0] leaf;
	logic        node_bad;

	assign desc   = from_node_q ? node_rdata : coarse_rdata;
	assign lvl_m1 = level_q - 2'd1;
	assign xb     = {1'b0, item_q.cell_x[2:0]};
	assign yb     = {1'b0, item_q.cell_y[2:0]};
	assign zb     = {1'b0, item_q.cell_z[2:0]};
	assign child  = {xb[lvl_m1], yb[lvl_m1], zb[lvl_m1]};
	assign leaf   = desc[14:0] & LEAF_MASK[14:0];

	assign node_bad = (desc >= {5'd0, node_count_q}) || (desc >= 16'(NODE_ENTRIES))
		|| (level_q == 2'd0);

	logic [16:0] coarse_wfull;
	logic [17:0] node_wfull, node_rfull;

	assign coarse_wfull = {5'd0, item_q.table_address};
	assign node_wfull   = {3'd0, item_q.table_address, item_q.child_slot};
	assign node_rfull   = {desc[14:0], child};

	always_comb begin
		priority if (desc == 16'd0) begin
			sts.kind = DK_EMPTY;
		end else if ((desc & LEAF_FLAG) != 16'd0) begin
			sts.kind = (leaf == 15'd0 || {1'b0, leaf} >= list_count_q) ? DK_BAD_LEAF : DK_LEAF;
		end else if (node_bad) begin
			sts.kind = DK_BAD_NODE;
		end else begin
			sts.kind = DK_DESCEND;
		end
		sts.cmd      = item_q.command;
		sts.dim_zero = (cx == 16'd0) || (cy == 16'd0) || (cz == 16'd0);
		sts.outside  = (item_q.cell_x >= grid_x_q) || (item_q.cell_y >= grid_y_q)
			|| (item_q.cell_z >= grid_z_q);
		sts.t_ovf    = (t_q[32:16] != 17'd0);
		sts.idx_ovf  = (idx_q >= 33'(COARSE_WORDS));
		if (item_q.command == CMD_WR_COARSE) begin
			sts.wr_addr_bad = (coarse_wfull >= 17'(COARSE_WORDS));
		end else begin
			sts.wr_addr_bad = ({4'd0, item_q.table_address} >= 16'(NODE_ENTRIES));
		end
		sts.out_free = !out_valid || out_ready;
	end

	ogcl_ram #(
		.WIDTH (16),
		.DEPTH (COARSE_WORDS)
	) u_coarse_ram (
		.clk   (clk),
		.we    (cmd.write_en && item_q.command == CMD_WR_COARSE),
		.waddr (coarse_wfull[CAW-1:0]),
		.wdata (item_q.word_value),
		.re    (cmd.start_walk),
		.raddr (idx_q[CAW-1:0]),
		.rdata (coarse_rdata)
	);

	ogcl_ram #(
		.WIDTH (16),
		.DEPTH (NODE_ENTRIES * 8)
	) u_node_ram (
		.clk   (clk),
		.we    (cmd.write_en && item_q.command == CMD_WR_NODE),
		.waddr (node_wfull[NAW-1:0]),
		.wdata (item_q.word_value),
		.re    (cmd.step_walk),
		.raddr (node_rfull[NAW-1:0]),
		.rdata (node_rdata)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_result.status      <= cmd.result;
			out_result.leaf_index  <= (cmd.result == RES_LEAF) ? leaf : 15'd0;
			out_result.levels_used <= levels_q;
		end
	end

endmodule

// ===== rtl/core/ogcl_checker.sv =====
`timescale 1ns / 1ps

module ogcl_checker
	import ogcl_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_BYTES*8-1:0] m_axis_tdata
);

	// A stalled result beat keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Only a leaf hit carries a cell-list index.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != 3'(RES_LEAF) |-> m_axis_tdata[17:3] == 15'd0)
		else $error("leaf index set on a non-leaf result");

	// Writes and checks that end before the tree report no levels.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == 3'(RES_WRITTEN)
			|| m_axis_tdata[2:0] == 3'(RES_OUTSIDE)
			|| m_axis_tdata[2:0] == 3'(RES_BAD_ADDR))
		|-> m_axis_tdata[19:18] == 2'd0)
		else $error("levels reported without a tree walk");

	// A result never follows its command in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared too early");

endmodule

bind octree_grid_cell_lookup_top ogcl_checker u_ogcl_checker (.*);

// ===== tb/octree_grid_cell_lookup_top_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the sparse octree cell lookup. Every input beat is one command
// and every command returns exactly one result beat, so the expected results
// form a simple in-order queue. A behavioral copy of the two tables and the
// six configuration registers predicts each result at the moment its command
// beat is accepted.
//
// Table entries must never be read before they have been written. Before a
// lookup is sent, the testbench walks its own copy of the tables for that
// cell. If the walk meets an entry that was never written, a write beat for
// that entry goes out first, with a word that is usually a valid node
// reference or leaf. The walk is then retried. Lookups therefore descend deep
// into the tree while the table content stays random.
module octree_grid_cell_lookup_top_tb;
	import ogcl_pkg::*;

	localparam int unsigned COARSE_WORDS = 4096;
	localparam int unsigned NODE_ENTRIES = 1024;
	localparam int unsigned MAX_DEPTH    = 3;
	// Length of the long output stall that backs the block up.
	localparam int unsigned LONG_HOLD    = 300;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// From bit 0: command, table_address, child_slot, word_value, cell_x,
	// cell_y, cell_z, zero pad.
	logic [IN_BYTES*8-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// From bit 0: status, leaf_index, levels_used, zero pad.
	logic [OUT_BYTES*8-1:0] m_axis_tdata;
	logic                   cfg_we;
	logic [2:0]             cfg_index;
	logic [15:0]            cfg_wdata;

	octree_grid_cell_lookup_top #(
		.COARSE_WORDS(COARSE_WORDS),
		.NODE_ENTRIES(NODE_ENTRIES),
		.MAX_DEPTH   (MAX_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Shadow of the block's registers and tables. The written flags let the
	// stimulus avoid reading an entry that holds nothing defined yet.
	logic [15:0] grid_x;
	logic [15:0] grid_y;
	logic [15:0] grid_z;
	logic [1:0]  depth_sel;
	logic [10:0] node_lim;
	logic [15:0] list_lim;
	bit [15:0]   coarse_mem [COARSE_WORDS];
	bit          coarse_set [COARSE_WORDS];
	bit [15:0]   node_mem [NODE_ENTRIES*8];
	bit          node_set [NODE_ENTRIES*8];

	result_t     cell_answers[$];
	int unsigned mismatch_count = 0;
	// Random idle bursts on both sides are on while this is set.
	bit          idle_on = 1'b1;
	// A nonzero value asks the output side for one long stall; the value sets its length.
	int unsigned long_hold_cycles = 0;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] ERROR %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Follows a lookup through the shadow tables. Returns 0 when the walk meets
	// an entry that was never written and names that entry; otherwise returns 1
	// with the result the block must give.
	function automatic bit walk_octree(input item_t it, output result_t res,
			output bit miss_node, output int unsigned miss_at);
		logic [15:0] dim_x, dim_y, dim_z, desc;
		logic [63:0] idx;
		logic [2:0]  child;
		int unsigned lvl, levels, entry;
		res = '0;
		miss_node = 1'b0;
		miss_at = 0;
		lvl = depth_sel;
		dim_x = grid_x >> lvl;
		dim_y = grid_y >> lvl;
		dim_z = grid_z >> lvl;
		// A coarse grid with an empty axis outranks the range check.
		if (dim_x == 0 || dim_y == 0 || dim_z == 0) begin
			res.status = RES_BAD_ADDR;
			return 1'b1;
		end
		if (it.cell_x >= grid_x || it.cell_y >= grid_y || it.cell_z >= grid_z) begin
			res.status = RES_OUTSIDE;
			return 1'b1;
		end
		idx = (64'(it.cell_x >> lvl) * dim_y + 64'(it.cell_y >> lvl)) * dim_z
			+ 64'(it.cell_z >> lvl);
		if (idx >= COARSE_WORDS) begin
			res.status = RES_BAD_ADDR;
			return 1'b1;
		end
		if (!coarse_set[idx]) begin
			miss_at = 32'(idx);
			return 1'b0;
		end
		desc = coarse_mem[idx];
		levels = 0;
		while (desc != 16'h0000 && (desc & LEAF_FLAG) == 16'h0000) begin
			// A node reference past either limit, or one more level than the
			// depth allows, ends the walk as a bad node.
			if (desc >= node_lim || desc >= NODE_ENTRIES || lvl == 0) begin
				res.status = RES_BAD_NODE;
				res.levels_used = 2'(levels);
				return 1'b1;
			end
			lvl = lvl - 1;
			levels = levels + 1;
			child = {it.cell_x[lvl], it.cell_y[lvl], it.cell_z[lvl]};
			entry = desc * 8 + child;
			if (!node_set[entry]) begin
				miss_node = 1'b1;
				miss_at = entry;
				return 1'b0;
			end
			desc = node_mem[entry];
		end
		res.levels_used = 2'(levels);
		if (desc == 16'h0000) begin
			res.status = RES_EMPTY;
		end else if ((desc & LEAF_MASK) == 16'h0000 || (desc & LEAF_MASK) >= list_lim) begin
			res.status = RES_BAD_LEAF;
		end else begin
			res.status = RES_LEAF;
			res.leaf_index = desc[14:0];
		end
		return 1'b1;
	endfunction

	// Works out the answer to one accepted command beat and applies its write.
	function automatic result_t answer_command(input item_t it);
		result_t     res;
		bit          miss_node;
		int unsigned miss_at, entry;
		res = '0;
		case (it.command)
			CMD_WR_COARSE: begin
				if (it.table_address >= COARSE_WORDS) begin
					res.status = RES_BAD_ADDR;
				end else begin
					coarse_mem[it.table_address] = it.word_value;
					coarse_set[it.table_address] = 1'b1;
					res.status = RES_WRITTEN;
				end
			end
			CMD_WR_NODE: begin
				if (it.table_address >= NODE_ENTRIES) begin
					res.status = RES_BAD_ADDR;
				end else begin
					entry = it.table_address * 8 + it.child_slot;
					node_mem[entry] = it.word_value;
					node_set[entry] = 1'b1;
					res.status = RES_WRITTEN;
				end
			end
			CMD_LOOKUP: begin
				void'(walk_octree(it, res, miss_node, miss_at));
			end
			default: begin
				res.status = RES_BAD_ADDR;
			end
		endcase
		return res;
	endfunction

	// Offers one command beat, possibly after an idle burst, and records its
	// answer once the beat is taken. Valid stays high after the handshake so
	// that back-to-back beats need no toggle in between.
	task automatic send_item(input item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_BYTES*8-IN_BITS){1'b0}}, it};
		do @(posedge clk); while (!s_axis_tready);
		cell_answers = {cell_answers, answer_command(it)};
	endtask

	function automatic item_t random_item(input cmd_e cmd);
		item_t it;
		it.command       = cmd;
		it.table_address = 12'($urandom);
		it.child_slot    = 3'($urandom);
		it.word_value    = 16'($urandom);
		it.cell_x        = 16'($urandom);
		it.cell_y        = 16'($urandom);
		it.cell_z        = 16'($urandom);
		return it;
	endfunction

	function automatic item_t cell_probe(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		item_t it;
		it = random_item(CMD_LOOKUP);
		it.cell_x = x;
		it.cell_y = y;
		it.cell_z = z;
		return it;
	endfunction

	// A table word that mostly keeps the walk going: node references below
	// the node count, good leaves, with some empty words, bad leaves and noise.
	function automatic logic [15:0] tree_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r <= 3)
			return LEAF_FLAG | 16'((list_lim > 1) ? $urandom_range(1, list_lim - 1) : 0);
		if (r == 4)
			return LEAF_FLAG | 16'($urandom_range(0, 32767));
		if (r <= 8)
			return 16'($urandom_range(1, (node_lim > 1) ? node_lim - 1 : 1));
		return 16'($urandom);
	endfunction

	// Coordinates inside the grid, leaning toward the far edge and the low
	// corner where the coarse index stays small.
	function automatic logic [15:0] pick_coord(input logic [15:0] size);
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return size - 1;
		if (r == 1)
			return 16'($urandom_range(0, (size > 32) ? 31 : size - 1));
		return 16'($urandom_range(0, size - 1));
	endfunction

	task automatic write_entry(input bit to_nodes, input int unsigned at,
			input logic [15:0] word);
		item_t it;
		it = random_item(to_nodes ? CMD_WR_NODE : CMD_WR_COARSE);
		it.table_address = to_nodes ? 12'(at >> 3) : 12'(at);
		it.child_slot    = 3'(at);
		it.word_value    = word;
		send_item(it);
	endtask

	// Sends a lookup, first filling every entry on its path that holds
	// nothing yet.
	task automatic look_up(input item_t it);
		result_t     res;
		bit          miss_node;
		int unsigned miss_at;
		while (!walk_octree(it, res, miss_node, miss_at))
			write_entry(miss_node, miss_at, tree_word());
		send_item(it);
	endtask

	// Lets every answer drain and the core go quiet before a register write.
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (cell_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Drives one register write. The caller lowers the write enable after the
	// last one so that it never toggles within a single step.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_GRID_X:     grid_x = val;
			REG_GRID_Y:     grid_y = val;
			REG_GRID_Z:     grid_z = val;
			REG_TREE_DEPTH: depth_sel = val[1:0];
			REG_NODE_COUNT: node_lim = val[10:0];
			REG_LIST_COUNT: list_lim = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] gx, input logic [15:0] gy,
			input logic [15:0] gz, input logic [1:0] depth, input logic [10:0] nodes,
			input logic [15:0] lists);
		settle_block();
		write_reg(REG_GRID_X, gx);
		write_reg(REG_GRID_Y, gy);
		write_reg(REG_GRID_Z, gz);
		write_reg(REG_TREE_DEPTH, 16'(depth));
		write_reg(REG_NODE_COUNT, 16'(nodes));
		write_reg(REG_LIST_COUNT, lists);
		cfg_we <= 1'b0;
	endtask

	// Random traffic under the current settings. Most beats are lookups inside
	// the grid; the rest are table writes, lookups anywhere, the unused
	// command and fully random beats.
	task automatic run_mix(input int unsigned count);
		item_t       it;
		int unsigned r;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r <= 10) begin
				look_up(cell_probe(pick_coord(grid_x), pick_coord(grid_y),
					pick_coord(grid_z)));
			end else if (r <= 12) begin
				look_up(random_item(CMD_LOOKUP));
			end else if (r <= 15) begin
				write_entry(1'b0, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, COARSE_WORDS - 1), tree_word());
			end else if (r <= 17) begin
				it = random_item(CMD_WR_NODE);
				if ($urandom_range(0, 7) != 0)
					it.table_address = 12'($urandom_range(0, node_lim - 1));
				it.word_value = tree_word();
				send_item(it);
			end else if (r == 18) begin
				send_item(random_item(CMD_RESERVED));
			end else begin
				it = random_item(cmd_e'($urandom_range(0, 3)));
				if (it.command == CMD_LOOKUP)
					look_up(it);
				else
					send_item(it);
			end
		end
	endtask

	// Reset settings: a single cell grid, no tree levels, one node, one list
	// entry. Also covers both write commands at their address limits and the
	// unused command.
	task automatic test_reset_settings();
		item_t it;
		write_entry(1'b0, 0, 16'h0000);
		look_up(cell_probe(16'd0, 16'd0, 16'd0));
		// With a node count of one, any node reference is out of range.
		write_entry(1'b0, 0, 16'h0001);
		look_up(cell_probe(16'd0, 16'd0, 16'd0));
		look_up(cell_probe(16'd0, 16'd0, 16'hffff));
		look_up(cell_probe(16'hffff, 16'hffff, 16'hffff));
		send_item(random_item(CMD_RESERVED));
		it = random_item(CMD_WR_NODE);
		it.table_address = 12'hfff;
		it.child_slot = 3'd7;
		it.word_value = 16'hffff;
		send_item(it);
		write_entry(1'b1, (NODE_ENTRIES - 1) * 8 + 7, 16'h0000);
		write_entry(1'b0, COARSE_WORDS - 1, 16'hffff);
	endtask

	// One coarse cell with three levels below it. The far corner walks the
	// full depth and ends on the largest leaf, then on a zero leaf, then on a
	// node reference with no level left. The near corner meets a reference
	// just past the node table.
	task automatic test_deepest_walk();
		load_config(16'd8, 16'd8, 16'd8, 2'd3, 11'd1024, 16'd32768);
		write_entry(1'b0, 0, 16'd5);
		write_entry(1'b1, 5 * 8 + 7, 16'd1023);
		write_entry(1'b1, 1023 * 8 + 7, 16'd9);
		write_entry(1'b1, 9 * 8 + 7, 16'hffff);
		look_up(cell_probe(16'd7, 16'd7, 16'd7));
		write_entry(1'b1, 9 * 8 + 7, LEAF_FLAG);
		look_up(cell_probe(16'd7, 16'd7, 16'd7));
		write_entry(1'b1, 9 * 8 + 7, 16'h0002);
		look_up(cell_probe(16'd7, 16'd7, 16'd7));
		write_entry(1'b1, 5 * 8 + 0, 16'(NODE_ENTRIES));
		look_up(cell_probe(16'd0, 16'd0, 16'd0));
	endtask

	// An axis that shrinks to zero at this depth wins over a cell outside the
	// grid; with the largest grid the coarse index runs past the table.
	task automatic test_coarse_limits();
		load_config(16'd4, 16'd4, 16'd4, 2'd3, 11'd1, 16'd1);
		look_up(cell_probe(16'd9, 16'd9, 16'd9));
		load_config(16'hffff, 16'hffff, 16'hffff, 2'd0, 11'd1, 16'd32768);
		look_up(cell_probe(16'd0, 16'd0, 16'(COARSE_WORDS - 1)));
		look_up(cell_probe(16'd0, 16'd0, 16'(COARSE_WORDS)));
		look_up(cell_probe(16'hfffe, 16'hfffe, 16'hfffe));
	endtask

	task automatic test_random_settings();
		load_config(16'd16, 16'd16, 16'd16, 2'd2, 11'd64, 16'd300);
		run_mix(50);
		repeat (2) begin
			load_config(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
				16'($urandom_range(1, 40)), 2'($urandom_range(0, 3)),
				11'($urandom_range(1, 1024)), 16'($urandom_range(1, 32768)));
			run_mix(50);
		end
		// No tree levels: every node reference in the coarse table is an error.
		load_config(16'd16, 16'd16, 16'd16, 2'd0, 11'd1024, 16'd32768);
		run_mix(35);
		load_config(16'hffff, 16'hffff, 16'hffff, 2'd3, 11'd1024, 16'd2);
		run_mix(35);
	endtask

	// The output side stops for a long stretch while beats keep coming, so the
	// result register and the core fill and the input side has to stall.
	task automatic test_backpressure();
		load_config(16'd16, 16'd16, 16'd16, 2'd3, 11'd200, 16'd5000);
		idle_on = 1'b0;
		long_hold_cycles = LONG_HOLD;
		run_mix(24);
		idle_on = 1'b1;
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		load_config(16'd32, 16'd32, 16'd32, 2'd3, 11'd512, 16'd1024);
		idle_on = 1'b0;
		run_mix(35);
	endtask

	// Output side: ready with random stall bursts, plus the long stall on
	// request.
	initial begin : sink_side
		int unsigned hold;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles != 0) begin
				hold = long_hold_cycles;
				long_hold_cycles = 0;
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Each result beat is checked against the oldest answer still owed.
	always @(posedge clk) begin : check_results
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[OUT_BITS-1:0]);
			if (cell_answers.size() == 0) begin
				report_mismatch("result beat with no command owed", got.status, 0);
			end else begin
				want = cell_answers.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.leaf_index !== want.leaf_index)
					report_mismatch("leaf_index", got.leaf_index, want.leaf_index);
				if (got.levels_used !== want.levels_used)
					report_mismatch("levels_used", got.levels_used, want.levels_used);
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : run_tests
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_GRID_X;
		cfg_wdata     = 16'h0000;
		grid_x        = 16'd1;
		grid_y        = 16'd1;
		grid_z        = 16'd1;
		depth_sel     = 2'd0;
		node_lim      = 11'd1;
		list_lim      = 16'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_deepest_walk();
		test_coarse_limits();
		test_random_settings();
		test_backpressure();
		test_full_rate();

		// Drain, then give the block time to show any stray result beat.
		s_axis_tvalid <= 1'b0;
		while (cell_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ogcl_pkg.sv
rtl/core/ogcl_ram.sv
rtl/core/ogcl_ctrl.sv
rtl/core/ogcl_dp.sv
rtl/core/octree_grid_cell_lookup_top.sv
rtl/core/ogcl_checker.sv
tb/octree_grid_cell_lookup_top_tb.sv
